### design/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property that holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("%m: assertion failed");

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### design/lex_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lex_pkg;

  // column saturation and field widths
  localparam int MAX_COLUMN = 4096;
  localparam int COL_W      = 13;
  localparam int LINE_W     = 16;
  localparam int ID_W       = 32;
  localparam int KIND_W     = 3;
  localparam int DEPTH_W    = 16;

  // token kinds
  localparam logic [KIND_W-1:0] KIND_WORD  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_OPEN  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CLOSE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_QUOTE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SEMI  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_COLON = 3'd5;

  // input actions
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_END  = 1'b1;

  // special bytes
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NEWLINE = 8'h0a;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_QUOTE   = 8'h27;
  localparam logic [7:0] CH_OPEN    = 8'h28;
  localparam logic [7:0] CH_CLOSE   = 8'h29;
  localparam logic [7:0] CH_STAR    = 8'h2a;
  localparam logic [7:0] CH_PLUS    = 8'h2b;
  localparam logic [7:0] CH_MINUS   = 8'h2d;
  localparam logic [7:0] CH_COLON   = 8'h3a;
  localparam logic [7:0] CH_SEMI    = 8'h3b;
  localparam logic [7:0] CH_EQUALS  = 8'h3d;

  // one result item
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [COL_W-1:0]  start_column;
    logic [COL_W-1:0]  end_column;
    logic [LINE_W-1:0] line_number;
    logic [ID_W-1:0]   token_id;
    logic              last;
  } token_t;

  // letters, digits and + - = *
  function automatic logic is_word_byte(input logic [7:0] c);
    logic r;
    case (c) inside
      ["0":"9"], ["A":"Z"], ["a":"z"]:          r = 1'b1;
      CH_PLUS, CH_MINUS, CH_EQUALS, CH_STAR:    r = 1'b1;
      default:                                  r = 1'b0;
    endcase
    return r;
  endfunction

  // saturating column step
  function automatic logic [COL_W-1:0] sat_inc(input logic [COL_W-1:0] v);
    return (v < COL_W'(MAX_COLUMN)) ? v + 1'b1 : v;
  endfunction

endpackage

`default_nettype wire

### design/lex_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lex_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] ch;

  modport source (output valid, output action, output ch, input ready);
  modport sink   (input valid, input action, input ch, output ready);
endinterface

`default_nettype wire

### design/lex_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lex_out_if;
  import lex_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [COL_W-1:0]  start_column;
  logic [COL_W-1:0]  end_column;
  logic [LINE_W-1:0] line_number;
  logic [ID_W-1:0]   token_id;
  logic              last;

  modport source (output valid, output kind, output start_column, output end_column,
                  output line_number, output token_id, output last, input ready);
  modport sink   (input valid, input kind, input start_column, input end_column,
                  input line_number, input token_id, input last, output ready);
endinterface

`default_nettype wire

### design/lexer_with_nested_comment_strip.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// channel | dir | payload                                               | per transfer
// src     | in  | action, ch                                            | one source byte
// tok     | out | kind, start_column, end_column, line_number, token_id, last | one token
//
// one source byte is taken per cycle while src.ready is high; its tokens reach the result
// queue at the same edge and tok.valid rises the cycle after. a byte that ends a word and is
// itself a token yields two transfers when both are kept. src.ready depends only on the
// four-entry result queue fill (at least two free slots). rst is synchronous and clears the
// lexer state, the queue and the token counter (back to 1); tok stalls only back up src.

module lexer_with_nested_comment_strip (
  input  wire logic clk,
  input  wire logic rst,
  lex_in_if.sink    src,
  lex_out_if.source tok
);
  import lex_pkg::*;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // lexer state
  logic               in_word;
  logic [COL_W-1:0]   word_start;
  logic [COL_W-1:0]   column;
  logic [LINE_W-1:0]  line_count;
  logic               line_has_content;
  logic [DEPTH_W-1:0] paren_depth;
  logic               in_comment;
  logic [ID_W-1:0]    next_id;

  logic               in_word_next;
  logic [COL_W-1:0]   word_start_next;
  logic [COL_W-1:0]   column_next;
  logic [LINE_W-1:0]  line_count_next;
  logic               line_has_content_next;
  logic [DEPTH_W-1:0] paren_depth_next;
  logic               in_comment_next;
  logic [ID_W-1:0]    next_id_next;

  // result queue
  token_t             queue [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  cnt;

  logic               acc;
  logic               pop;
  logic               word_keep;
  logic               single_keep;
  token_t             word_res;
  token_t             single_res;
  logic [1:0]         push_n;

  assign acc = src.valid && src.ready;
  assign pop = tok.valid && tok.ready;
  assign src.ready = (cnt <= QCNT_W'(QDEPTH - 2));

  // next state and the tokens this byte closes
  always_comb begin
    logic              is_single;
    logic              delim;
    logic [KIND_W-1:0] skind;

    in_word_next          = in_word;
    word_start_next       = word_start;
    column_next           = column;
    line_count_next       = line_count;
    line_has_content_next = line_has_content;
    paren_depth_next      = paren_depth;
    in_comment_next       = in_comment;
    next_id_next          = next_id;
    word_keep             = 1'b0;
    single_keep           = 1'b0;
    delim                 = 1'b0;
    is_single             = 1'b1;

    case (src.ch)
      CH_OPEN:  skind = KIND_OPEN;
      CH_CLOSE: skind = KIND_CLOSE;
      CH_QUOTE: skind = KIND_QUOTE;
      CH_SEMI:  skind = KIND_SEMI;
      CH_COLON: skind = KIND_COLON;
      default: begin
        skind     = KIND_WORD;
        is_single = 1'b0;
      end
    endcase

    word_res.kind         = KIND_WORD;
    word_res.start_column = word_start;
    word_res.end_column   = column;
    word_res.line_number  = line_count;
    word_res.token_id     = next_id;
    word_res.last         = 1'b1;

    single_res.kind         = skind;
    single_res.start_column = column;
    single_res.end_column   = sat_inc(column);
    single_res.line_number  = line_count;
    single_res.token_id     = next_id + ID_W'(in_word);
    single_res.last         = 1'b1;

    if (src.action == ACT_END) begin
      // flush pending word, back to reset values except the id counter
      word_keep             = in_word && !in_comment;
      next_id_next          = next_id + ID_W'(in_word);
      in_word_next          = 1'b0;
      word_start_next       = '0;
      column_next           = '0;
      line_count_next       = '0;
      line_has_content_next = 1'b0;
      paren_depth_next      = DEPTH_W'(1);
      in_comment_next       = 1'b0;
    end else if (is_word_byte(src.ch)) begin
      if (!in_word) begin
        in_word_next    = 1'b1;
        word_start_next = column;
      end
      line_has_content_next = 1'b1;
      column_next           = sat_inc(column);
    end else begin
      // word closed by a non-word byte
      word_keep    = in_word && !in_comment;
      in_word_next = 1'b0;
      next_id_next = next_id + ID_W'(in_word) + ID_W'(is_single);

      // outermost parens toggle comment mode and are dropped
      if (skind == KIND_OPEN) begin
        delim            = (paren_depth == DEPTH_W'(1));
        paren_depth_next = paren_depth + 1'b1;
      end else if (skind == KIND_CLOSE) begin
        paren_depth_next = paren_depth - 1'b1;
        delim            = (paren_depth_next == DEPTH_W'(1));
      end
      if (delim) begin
        in_comment_next = !in_comment;
      end
      single_keep = is_single && !delim && !in_comment;

      // line and column tracking
      if (src.ch == CH_NEWLINE) begin
        line_count_next       = line_count + LINE_W'(line_has_content);
        line_has_content_next = 1'b0;
        column_next           = '0;
      end else begin
        if (src.ch != CH_SPACE && src.ch != CH_TAB && src.ch != CH_NUL) begin
          line_has_content_next = 1'b1;
        end
        column_next = sat_inc(column);
      end
    end

    // a kept word followed by a kept token is not the last result
    if (word_keep && single_keep) begin
      word_res.last = 1'b0;
    end
    push_n = acc ? (2'(word_keep) + 2'(single_keep)) : 2'd0;
  end

  // lexer state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      in_word          <= 1'b0;
      word_start       <= '0;
      column           <= '0;
      line_count       <= '0;
      line_has_content <= 1'b0;
      paren_depth      <= DEPTH_W'(1);
      in_comment       <= 1'b0;
      next_id          <= ID_W'(1);
    end else if (acc) begin
      in_word          <= in_word_next;
      word_start       <= word_start_next;
      column           <= column_next;
      line_count       <= line_count_next;
      line_has_content <= line_has_content_next;
      paren_depth      <= paren_depth_next;
      in_comment       <= in_comment_next;
      next_id          <= next_id_next;
    end
  end

  // result queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push_n);
      rd_ptr <= rd_ptr + QPTR_W'(pop);
      cnt    <= cnt + QCNT_W'(push_n) - QCNT_W'(pop);
    end
  end

  // result queue storage, word first when both are kept
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      queue[wr_ptr] <= word_keep ? word_res : single_res;
    end
    if (push_n == 2'd2) begin
      queue[wr_ptr + 1'b1] <= single_res;
    end
  end

  // output side
  assign tok.valid        = (cnt != '0);
  assign tok.kind         = queue[rd_ptr].kind;
  assign tok.start_column = queue[rd_ptr].start_column;
  assign tok.end_column   = queue[rd_ptr].end_column;
  assign tok.line_number  = queue[rd_ptr].line_number;
  assign tok.token_id     = queue[rd_ptr].token_id;
  assign tok.last         = queue[rd_ptr].last;

  // checks
  `ASSERT_ALWAYS(a_queue_bound, clk, rst, cnt <= QCNT_W'(QDEPTH))
  `ASSERT_NEXT(a_id_hold, clk, rst, !acc, next_id == $past(next_id))
  `ASSERT_IMPLIES(a_pair_whole, clk, rst, tok.valid && !tok.last, cnt >= QCNT_W'(2))

endmodule

`default_nettype wire

### test/lexer_with_nested_comment_strip_test.sv
`timescale 1ns / 1ps

module lexer_with_nested_comment_strip_test;
  import lex_pkg::*;

  // one source item queued for the driver
  typedef struct packed {
    logic       action;
    logic [7:0] ch;
    logic       hold;
    logic [1:0] phase;
  } src_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lex_in_if  src ();
  lex_out_if tok ();

  lexer_with_nested_comment_strip dut (
    .clk (clk),
    .rst (rst),
    .src (src),
    .tok (tok)
  );

  // clock, 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  src_item_t source_bytes[$];
  src_item_t head;
  token_t    expected_tokens[$];
  token_t    want;

  // generator bookkeeping
  logic [1:0] gen_phase = 2'd0;
  logic       hold_next = 1'b0;
  logic [1:0] cur_phase = 2'd0;

  int items_total    = 0;
  int bytes_sent     = 0;
  int ends_sent      = 0;
  int tokens_checked = 0;
  int words_checked  = 0;
  int failures       = 0;
  int max_col_seen   = 0;
  int max_line_seen  = 0;

  // lexer state mirror
  logic              in_word_q;
  logic [COL_W-1:0]  word_start_q;
  logic [COL_W-1:0]  column_q;
  logic [LINE_W-1:0] line_count_q;
  logic              line_has_content_q;
  logic [DEPTH_W-1:0] depth_q;
  logic              in_comment_q;
  logic [ID_W-1:0]   next_id_q;

  // tokens produced by one source item
  token_t step_toks[2];
  int     step_n;

  // idle percentages per phase
  function automatic int sender_gap(input logic [1:0] ph);
    case (ph)
      2'd0:    return 32;
      2'd1:    return 52;
      default: return 0;
    endcase
  endfunction

  function automatic int receiver_stall(input logic [1:0] ph);
    case (ph)
      2'd0:    return 52;
      2'd1:    return 32;
      default: return 0;
    endcase
  endfunction

  // column advance, held at the saturation point
  function automatic logic [COL_W-1:0] col_step(input logic [COL_W-1:0] v);
    return (v < COL_W'(MAX_COLUMN)) ? COL_W'(v + 1) : v;
  endfunction

  // letters, digits and the four operator characters
  function automatic logic word_char(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5a) ||
           (c >= 8'h61 && c <= 8'h7a) || c == CH_PLUS || c == CH_MINUS ||
           c == CH_EQUALS || c == CH_STAR;
  endfunction

  // everything but the token counter back to its start value
  task automatic clear_position();
    in_word_q          = 1'b0;
    word_start_q       = '0;
    column_q           = '0;
    line_count_q       = '0;
    line_has_content_q = 1'b0;
    depth_q            = DEPTH_W'(1);
    in_comment_q       = 1'b0;
  endtask

  // number a token, track parens and comment mode, keep it if visible
  task automatic number_token(input logic [KIND_W-1:0] kind,
                              input logic [COL_W-1:0] s, input logic [COL_W-1:0] e);
    token_t t;
    logic   delim;
    delim            = 1'b0;
    t.kind           = kind;
    t.start_column   = s;
    t.end_column     = e;
    t.line_number    = line_count_q;
    t.token_id       = next_id_q;
    t.last           = 1'b0;
    next_id_q        = next_id_q + 1'b1;
    if (kind == KIND_OPEN) begin
      delim   = (depth_q == DEPTH_W'(1));
      depth_q = depth_q + 1'b1;
    end else if (kind == KIND_CLOSE) begin
      depth_q = depth_q - 1'b1;
      delim   = (depth_q == DEPTH_W'(1));
    end
    if (delim) begin
      in_comment_q = !in_comment_q;
    end else if (!in_comment_q && step_n < 2) begin
      step_toks[step_n] = t;
      step_n++;
    end
  endtask

  // advance the lexer mirror by one source item and queue its tokens
  task automatic lex_step(input logic act, input logic [7:0] c);
    step_n = 0;
    if (act == ACT_END) begin
      if (in_word_q) number_token(KIND_WORD, word_start_q, column_q);
      clear_position();
    end else if (word_char(c)) begin
      if (!in_word_q) begin
        in_word_q    = 1'b1;
        word_start_q = column_q;
      end
      line_has_content_q = 1'b1;
      column_q           = col_step(column_q);
    end else begin
      if (in_word_q) begin
        number_token(KIND_WORD, word_start_q, column_q);
        in_word_q = 1'b0;
      end
      case (c)
        CH_OPEN:  number_token(KIND_OPEN, column_q, col_step(column_q));
        CH_CLOSE: number_token(KIND_CLOSE, column_q, col_step(column_q));
        CH_QUOTE: number_token(KIND_QUOTE, column_q, col_step(column_q));
        CH_SEMI:  number_token(KIND_SEMI, column_q, col_step(column_q));
        CH_COLON: number_token(KIND_COLON, column_q, col_step(column_q));
        default:  ;
      endcase
      if (c == CH_NEWLINE) begin
        if (line_has_content_q) line_count_q = line_count_q + 1'b1;
        line_has_content_q = 1'b0;
        column_q           = '0;
      end else begin
        if (c != CH_SPACE && c != CH_TAB && c != CH_NUL) line_has_content_q = 1'b1;
        column_q = col_step(column_q);
      end
    end
    if (step_n > 0) step_toks[step_n-1].last = 1'b1;
    for (int i = 0; i < step_n; i++) expected_tokens.push_back(step_toks[i]);
  endtask

  // stimulus building
  task automatic add_item(input logic act, input logic [7:0] c);
    src_item_t it;
    it.action = act;
    it.ch     = c;
    it.hold   = hold_next;
    it.phase  = gen_phase;
    hold_next = 1'b0;
    source_bytes.push_back(it);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_item(ACT_BYTE, s[i]);
  endtask

  function automatic logic [7:0] rand_word_char();
    int r;
    r = $urandom_range(65);
    if (r < 10) return 8'(8'h30 + r);        // digit
    if (r < 36) return 8'(8'h41 + r - 10);   // upper case
    if (r < 62) return 8'(8'h61 + r - 36);   // lower case
    case (r)
      62:      return CH_PLUS;
      63:      return CH_MINUS;
      64:      return CH_EQUALS;
      default: return CH_STAR;
    endcase
  endfunction

  task automatic add_word(input int len);
    repeat (len) add_item(ACT_BYTE, rand_word_char());
  endtask

  function automatic logic [7:0] rand_single();
    case ($urandom_range(6))
      0, 1:    return CH_OPEN;
      2, 3:    return CH_CLOSE;
      4:       return CH_QUOTE;
      5:       return CH_SEMI;
      default: return CH_COLON;
    endcase
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      failures++;
    end
  endtask

  // driver: offers queued source items, updates the mirror on each transfer
  always @(posedge clk) begin
    if (rst) begin
      src.valid <= 1'b0;
    end else begin
      if (src.valid && src.ready) begin
        lex_step(src.action, src.ch);
        bytes_sent++;
        if (src.action == ACT_END) ends_sent++;
      end
      if (!src.valid || src.ready) begin
        if (source_bytes.size() > 0 &&
            !(source_bytes[0].hold && expected_tokens.size() > 0) &&
            $urandom_range(99) >= sender_gap(source_bytes[0].phase)) begin
          head = source_bytes.pop_front();
          src.valid  <= 1'b1;
          src.action <= head.action;
          src.ch     <= head.ch;
          cur_phase  <= head.phase;
        end else begin
          src.valid <= 1'b0;
        end
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    tok.ready <= ($urandom_range(99) >= receiver_stall(cur_phase));
  end

  // monitor: every token transfer against the oldest expectation
  always @(posedge clk) begin
    if (!rst && tok.valid && tok.ready) begin
      if (expected_tokens.size() == 0) begin
        $error("unexpected token: kind %0d id %0d", tok.kind, tok.token_id);
        failures++;
      end else begin
        want = expected_tokens.pop_front();
        check_field("kind", want.kind, tok.kind);
        check_field("start_column", want.start_column, tok.start_column);
        check_field("end_column", want.end_column, tok.end_column);
        check_field("line_number", want.line_number, tok.line_number);
        check_field("token_id", want.token_id, tok.token_id);
        check_field("last", want.last, tok.last);
        tokens_checked++;
        if (want.kind == KIND_WORD) words_checked++;
        if (want.end_column > max_col_seen) max_col_seen = want.end_column;
        if (want.line_number > max_line_seen) max_line_seen = want.line_number;
      end
    end
  end

  // hang guard
  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int n;
    int r;
    src.valid  = 1'b0;
    src.action = ACT_BYTE;
    src.ch     = CH_NUL;
    tok.ready  = 1'b0;
    clear_position();
    next_id_q  = ID_W'(1);

    // directed: word ending on a token, all single tokens, nested comment,
    // stray close, blank line, other-byte line, end with and without a word
    add_text("Az9*;:'(a())");
    add_text(")\n \t");
    add_item(ACT_BYTE, CH_NUL);
    add_item(ACT_BYTE, CH_NEWLINE);
    add_item(ACT_BYTE, 8'hff);
    add_item(ACT_BYTE, CH_NEWLINE);
    add_text("Z+-=");
    add_item(ACT_END, CH_NUL);
    add_item(ACT_END, 8'hff);

    // random source text, three idling phases of about equal length
    while (source_bytes.size() < 850) begin
      n = source_bytes.size();
      if (n >= 566 && gen_phase != 2'd2) begin
        gen_phase = 2'd2;
        hold_next = 1'b1;
      end else if (n >= 283 && gen_phase == 2'd0) begin
        gen_phase = 2'd1;
        hold_next = 1'b1;
      end
      r = $urandom_range(99);
      if (r < 30) begin
        add_word($urandom_range(6, 1));
      end else if (r < 45) begin
        add_item(ACT_BYTE, rand_single());
      end else if (r < 58) begin
        add_item(ACT_BYTE, $urandom_range(3) != 0 ? CH_SPACE : CH_TAB);
      end else if (r < 68) begin
        add_item(ACT_BYTE, CH_NEWLINE);
      end else if (r < 78) begin
        add_item(ACT_BYTE, 8'($urandom_range(255)));
      end else if (r < 86) begin
        add_word($urandom_range(4, 1));
        add_item(ACT_BYTE, rand_single());
      end else if (r < 90) begin
        add_item(ACT_END, 8'($urandom_range(255)));
      end else if (r < 95) begin
        add_item(ACT_BYTE, CH_SPACE);
        add_item(ACT_BYTE, CH_NUL);
        add_item(ACT_BYTE, CH_NEWLINE);
      end else begin
        // well-formed nested comment with words inside
        add_item(ACT_BYTE, CH_OPEN);
        add_word($urandom_range(3, 1));
        add_item(ACT_BYTE, CH_SPACE);
        add_item(ACT_BYTE, CH_OPEN);
        add_word($urandom_range(3, 1));
        add_item(ACT_BYTE, CH_CLOSE);
        add_item(ACT_BYTE, CH_CLOSE);
      end
    end
    add_item(ACT_END, CH_NUL);

    items_total = source_bytes.size();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (bytes_sent != items_total) @(posedge clk);
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (expected_tokens.size() != 0) begin
      $error("%0d expected tokens never arrived", expected_tokens.size());
      failures++;
    end

    $display("sent %0d source items (%0d end-of-source), compared %0d tokens (%0d words)",
             bytes_sent, ends_sent, tokens_checked, words_checked);
    $display("widest end column %0d, highest line number %0d, %0d mismatches",
             max_col_seen, max_line_seen, failures);
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
